// ----- sv/replication_progress_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// replication_progress_tracker_macros.svh
// Assertion macros used by the replication progress tracker checker.
// ----------------------------------------------------------------------------
`ifndef REPLICATION_PROGRESS_TRACKER_MACROS_SVH
`define REPLICATION_PROGRESS_TRACKER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst is high
`define RPT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("replication progress tracker assertion failed");

// Next-cycle implication, clocked on clk, off while rst is high
`define RPT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("replication progress tracker assertion failed");

`endif

// ----- sv/rpt_pkg.sv -----
// ----------------------------------------------------------------------------
// rpt_pkg
// Types, codes and helpers for the replication progress tracker.
// ----------------------------------------------------------------------------
package rpt_pkg;

  // Default number of ring slots
  localparam int WINDOW_DEPTH_DEF = 256;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // Request codes
  localparam logic [3:0] REQ_ADD        = 4'd0;
  localparam logic [3:0] REQ_FREE_TO    = 4'd1;
  localparam logic [3:0] REQ_FREE_FIRST = 4'd2;
  localparam logic [3:0] REQ_ACK        = 4'd3;
  localparam logic [3:0] REQ_REJECT     = 4'd4;
  localparam logic [3:0] REQ_PROBE      = 4'd5;
  localparam logic [3:0] REQ_REPLICATE  = 4'd6;
  localparam logic [3:0] REQ_SNAPSHOT   = 4'd7;
  localparam logic [3:0] REQ_PAUSE      = 4'd8;

  typedef enum logic [1:0] {
    MODE_PROBE     = 2'd0,
    MODE_REPLICATE = 2'd1,
    MODE_SNAPSHOT  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [63:0] index_a;
    logic [63:0] index_b;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        window_full_error;
    logic [1:0]  mode;
    logic [63:0] next_index;
    logic [63:0] match_index;
    logic [63:0] snapshot_index;
    logic        is_paused_out;
    logic        snapshot_abort;
    logic [8:0]  window_count;
  } rsp_t;

  // Increment that sticks at all ones
  function automatic logic [63:0] sat_inc(input logic [63:0] v);
    return (v == ALL_ONES) ? ALL_ONES : v + 64'd1;
  endfunction

endpackage

// ----- sv/replication_progress_tracker.sv -----
// ----------------------------------------------------------------------------
// replication_progress_tracker
// Leader-side progress state of one follower with an in-flight append window.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------
//   cfg     | in        | cfg_wr_en                  | cfg_wr_data (window size)
//   req     | in        | req_valid / req_ready      | rpt_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_ready      | rpt_pkg::rsp_t
//
// Accept (IDLE), execute (EXEC) and load the result register (FINISH) for each
// event. A free on a non-empty window walks the ring (WALK) between execute and
// finish, one RAM read per cycle, until an entry stays or the window empties.
// Reset is synchronous with no clearing pass; ring entries are read only once
// written. A waiting result does not block acceptance of the next request,
// but that request finishes only once the output register is free.
// ----------------------------------------------------------------------------
module replication_progress_tracker #(
  parameter int WINDOW_DEPTH = rpt_pkg::WINDOW_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [8:0]    cfg_wr_data,
  input  logic          req_valid,
  output logic          req_ready,
  input  rpt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rpt_pkg::rsp_t rsp
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

  rpt_pkg::state_t state, state_next;
  rpt_pkg::mode_t  mode_reg, mode_next;

  logic [CW-1:0] eff, eff_next;
  logic [63:0]   next_reg, next_next;
  logic [63:0]   match_reg, match_next;
  logic [63:0]   pending_reg, pending_next;
  logic          pause_flag, pause_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] fill, fill_next;
  logic          rsp_valid_next;
  rpt_pkg::rsp_t rsp_next;

  // Latched request and per-event flags
  logic [3:0]  op, op_next;
  logic [63:0] a_reg, a_next;
  logic [63:0] b_reg, b_next;
  logic [63:0] bound, bound_next;
  logic        load_bound, load_bound_next;
  logic        acc, acc_next;
  logic        err, err_next;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  // Window helpers
  logic          full;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] tail_wrap;
  logic [AW-1:0] tail_addr;
  logic [CW-1:0] head_plus;
  logic [AW-1:0] head_inc;
  logic [63:0]   bound_cmp;
  logic          walk_take;
  logic          rsp_load;
  logic [63:0]   rej_lim;
  logic [63:0]   rej_val;
  logic [63:0]   probe_base;

  assign full      = (fill >= eff);
  assign tail_sum  = SW'(head) + SW'(fill);
  assign tail_wrap = (tail_sum >= SW'(eff)) ? tail_sum - SW'(eff) : tail_sum;
  assign tail_addr = AW'(tail_wrap);
  assign head_plus = CW'(head) + CW'(1);
  assign head_inc  = (head_plus == eff) ? '0 : AW'(head_plus);
  assign bound_cmp = load_bound ? ram_rdata : bound;
  assign walk_take = (bound_cmp >= ram_rdata);

  // Reject and probe operands
  assign rej_lim    = rpt_pkg::sat_inc(b_reg);
  assign rej_val    = (a_reg < rej_lim) ? a_reg : rej_lim;
  assign probe_base = (match_reg > pending_reg) ? match_reg : pending_reg;

  rpt_ram #(
    .WIDTH (64),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_addr),
    .wdata (a_reg),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rpt_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = rpt_pkg::ST_EXEC;
        end
      end
      rpt_pkg::ST_EXEC: begin
        if ((op inside {rpt_pkg::REQ_FREE_TO, rpt_pkg::REQ_FREE_FIRST}) && (fill != '0)) begin
          state_next = rpt_pkg::ST_WALK;
        end else begin
          state_next = rpt_pkg::ST_FINISH;
        end
      end
      rpt_pkg::ST_WALK: begin
        if (!walk_take || (fill == CW'(1))) begin
          state_next = rpt_pkg::ST_FINISH;
        end
      end
      rpt_pkg::ST_FINISH: begin
        if (rsp_load) begin
          state_next = rpt_pkg::ST_IDLE;
        end
      end
      default: state_next = rpt_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    req_ready = (state == rpt_pkg::ST_IDLE) && !rst;
    rsp_load  = (state == rpt_pkg::ST_FINISH) && (!rsp_valid || rsp_ready);
    ram_we    = (state == rpt_pkg::ST_EXEC) && (op == rpt_pkg::REQ_ADD) && !full;
    ram_raddr = (state == rpt_pkg::ST_WALK) ? head_inc : head;
  end

  // Datapath
  always_comb begin
    mode_next       = mode_reg;
    eff_next        = eff;
    next_next       = next_reg;
    match_next      = match_reg;
    pending_next    = pending_reg;
    pause_next      = pause_flag;
    head_next       = head;
    fill_next       = fill;
    op_next         = op;
    a_next          = a_reg;
    b_next          = b_reg;
    bound_next      = bound;
    load_bound_next = load_bound;
    acc_next        = acc;
    err_next        = err;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid;

    case (state)
      rpt_pkg::ST_IDLE: begin
        if (req_valid) begin
          op_next    = req.req_type;
          a_next     = req.index_a;
          b_next     = req.index_b;
          bound_next = req.index_a;
        end
      end

      rpt_pkg::ST_EXEC: begin
        acc_next        = 1'b0;
        err_next        = 1'b0;
        load_bound_next = (op == rpt_pkg::REQ_FREE_FIRST);
        case (op)
          rpt_pkg::REQ_ADD: begin
            if (full) begin
              err_next = 1'b1;
            end else begin
              fill_next = fill + CW'(1);
              acc_next  = 1'b1;
            end
          end
          rpt_pkg::REQ_ACK: begin
            if (match_reg < a_reg) begin
              match_next = a_reg;
              pause_next = 1'b0;
              acc_next   = 1'b1;
            end
            if (next_reg < rpt_pkg::sat_inc(a_reg)) begin
              next_next = rpt_pkg::sat_inc(a_reg);
            end
          end
          rpt_pkg::REQ_REJECT: begin
            if (mode_reg == rpt_pkg::MODE_REPLICATE) begin
              if (a_reg > match_reg) begin
                next_next = rpt_pkg::sat_inc(match_reg);
                acc_next  = 1'b1;
              end
            end else if (next_reg - 64'd1 == a_reg) begin
              next_next  = (rej_val == 64'd0) ? 64'd1 : rej_val;
              pause_next = 1'b0;
              acc_next   = 1'b1;
            end
          end
          rpt_pkg::REQ_PROBE: begin
            mode_next    = rpt_pkg::MODE_PROBE;
            pause_next   = 1'b0;
            pending_next = '0;
            head_next    = '0;
            fill_next    = '0;
            if (mode_reg == rpt_pkg::MODE_SNAPSHOT) begin
              next_next = rpt_pkg::sat_inc(probe_base);
            end else begin
              next_next = rpt_pkg::sat_inc(match_reg);
            end
          end
          rpt_pkg::REQ_REPLICATE: begin
            mode_next    = rpt_pkg::MODE_REPLICATE;
            pause_next   = 1'b0;
            pending_next = '0;
            head_next    = '0;
            fill_next    = '0;
            next_next    = rpt_pkg::sat_inc(match_reg);
          end
          rpt_pkg::REQ_SNAPSHOT: begin
            mode_next    = rpt_pkg::MODE_SNAPSHOT;
            pause_next   = 1'b0;
            pending_next = a_reg;
            head_next    = '0;
            fill_next    = '0;
          end
          rpt_pkg::REQ_PAUSE: begin
            pause_next = 1'b1;
          end
          default: begin
            // free events start the walk on a non-empty window; unknown codes change nothing
          end
        endcase
      end

      // Release the oldest entry while the bound covers it
      rpt_pkg::ST_WALK: begin
        load_bound_next = 1'b0;
        if (load_bound) begin
          bound_next = ram_rdata;
        end
        if (walk_take) begin
          fill_next = fill - CW'(1);
          head_next = (fill == CW'(1)) ? '0 : head_inc;
        end
      end

      rpt_pkg::ST_FINISH: begin
        if (rsp_load) begin
          rsp_next.accepted          = acc;
          rsp_next.window_full_error = err;
          rsp_next.mode              = mode_reg;
          rsp_next.next_index        = next_reg;
          rsp_next.match_index       = match_reg;
          rsp_next.snapshot_index    = pending_reg;
          case (mode_reg)
            rpt_pkg::MODE_PROBE:     rsp_next.is_paused_out = pause_flag;
            rpt_pkg::MODE_REPLICATE: rsp_next.is_paused_out = full;
            default:                 rsp_next.is_paused_out = 1'b1;
          endcase
          rsp_next.snapshot_abort = (mode_reg == rpt_pkg::MODE_SNAPSHOT) &&
                                    (match_reg >= pending_reg);
          rsp_next.window_count   = 9'(fill);
        end
      end

      default: begin
      end
    endcase

    // Result register handshake
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    // Window size write empties the window; saturate to 1..depth
    if (cfg_wr_en) begin
      if (cfg_wr_data == 9'd0) begin
        eff_next = CW'(1);
      end else if (int'(cfg_wr_data) > WINDOW_DEPTH) begin
        eff_next = DEPTH_C;
      end else begin
        eff_next = CW'(cfg_wr_data);
      end
      head_next = '0;
      fill_next = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rpt_pkg::ST_IDLE;
      mode_reg    <= rpt_pkg::MODE_PROBE;
      eff         <= DEPTH_C;
      next_reg    <= 64'd1;
      match_reg   <= '0;
      pending_reg <= '0;
      pause_flag  <= 1'b0;
      head        <= '0;
      fill        <= '0;
      load_bound  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      mode_reg    <= mode_next;
      eff         <= eff_next;
      next_reg    <= next_next;
      match_reg   <= match_next;
      pending_reg <= pending_next;
      pause_flag  <= pause_next;
      head        <= head_next;
      fill        <= fill_next;
      load_bound  <= load_bound_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op    <= op_next;
    a_reg <= a_next;
    b_reg <= b_next;
    bound <= bound_next;
    acc   <= acc_next;
    err   <= err_next;
    rsp   <= rsp_next;
  end

endmodule

// ----- sv/rpt_ram.sv -----
// ----------------------------------------------------------------------------
// rpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = rpt_pkg::WINDOW_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rpt_checker.sv -----
// ----------------------------------------------------------------------------
// rpt_checker
// Port-level assertions for the replication progress tracker, bound to it.
// ----------------------------------------------------------------------------
`include "replication_progress_tracker_macros.svh"

module rpt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input rpt_pkg::rsp_t rsp
);

  // One request at a time: ready drops right after a transaction
  `RPT_ASSERT_NXT(a_req_single, req_valid && req_ready, !req_ready)

  // A stalled result holds
  `RPT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // Snapshot mode always reports paused
  `RPT_ASSERT_IMP(a_snap_paused, rsp_valid && (rsp.mode == rpt_pkg::MODE_SNAPSHOT), rsp.is_paused_out)

  // Abort only in snapshot mode
  `RPT_ASSERT_IMP(a_abort_mode, rsp_valid && (rsp.mode != rpt_pkg::MODE_SNAPSHOT), !rsp.snapshot_abort)

  // A rejected add is never also accepted, and a full window is not empty
  `RPT_ASSERT_IMP(a_full_err, rsp_valid && rsp.window_full_error, !rsp.accepted && (rsp.window_count != 9'd0))

endmodule

bind replication_progress_tracker rpt_checker u_rpt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ----- tb/replication_progress_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replication_progress_tracker_tb
// Drives request transactions into the follower progress tracker and checks
// every result against an in-bench model of the follower state: mode, next,
// match, pending snapshot, pause flag and the in-flight append ring. Runs a
// directed opening, then random phases under several window sizes, with
// random idling on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module replication_progress_tracker_tb;

  localparam int DEPTH = rpt_pkg::WINDOW_DEPTH_DEF;
  localparam int QUIET_LIMIT = 4000;   // cycles with no transaction at all
  localparam int HOLD_AT = 230;        // result count that starts the long hold
  localparam int HOLD_CYCLES = 500;
  localparam int PHASE_ITEMS = 110;
  localparam int NUM_PHASES = 10;

  // Model copies: one steered by the stimulus planner, one by the checker
  localparam int PLAN = 0;
  localparam int LIVE = 1;

  // Request codes beyond the defined set
  localparam logic [3:0] REQ_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] REQ_UNKNOWN_HI = 4'd15;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_wr_en = 1'b0;
  logic [8:0]    cfg_wr_data = '0;
  logic          req_valid = 1'b0;
  logic          req_ready;
  rpt_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  rpt_pkg::rsp_t rsp;

  // Follower progress state, two copies
  rpt_pkg::mode_t pr_mode  [2];
  logic [63:0]    pr_next  [2];
  logic [63:0]    pr_match [2];
  logic [63:0]    pr_pend  [2];
  bit             pr_pause [2];
  logic [63:0]    pr_ring  [2][DEPTH];
  int             pr_head  [2];
  int             pr_fill  [2];
  logic [8:0]     win_setting = 9'd256;

  rpt_pkg::req_t event_q[$];
  rpt_pkg::rsp_t progress_due[$];
  logic [63:0]   log_top = 64'd200;

  bit calm = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int taken = 0;
  int sent = 0;
  int checked = 0;
  int failures = 0;
  int full_seen = 0;
  int abort_seen = 0;
  int quiet = 0;
  rpt_pkg::rsp_t due;

  replication_progress_tracker dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Follower progress model
  // ---------------------------------------------------------------------------
  function automatic int ring_slots();
    if (win_setting == 9'd0) return 1;
    if (win_setting > DEPTH) return DEPTH;
    return int'(win_setting);
  endfunction

  function automatic logic [63:0] step_up(logic [63:0] v);
    return (v == rpt_pkg::ALL_ONES) ? v : v + 64'd1;
  endfunction

  // Release entries from the oldest on while they are not above the bound
  function automatic void window_release(int c, logic [63:0] bound);
    int pos;
    int n;
    if (pr_fill[c] == 0) return;
    pos = pr_head[c];
    if (bound < pr_ring[c][pos]) return;
    for (n = 0; n < pr_fill[c]; n++) begin
      if (bound < pr_ring[c][pos]) break;
      pos = (pos + 1) % ring_slots();
    end
    pr_fill[c] -= n;
    pr_head[c] = (pr_fill[c] == 0) ? 0 : pos;
  endfunction

  function automatic void switch_mode(int c, rpt_pkg::mode_t m);
    pr_pause[c] = 1'b0;
    pr_pend[c] = '0;
    pr_mode[c] = m;
    pr_head[c] = 0;
    pr_fill[c] = 0;
  endfunction

  function automatic rpt_pkg::rsp_t follower_step(int c, rpt_pkg::req_t r);
    rpt_pkg::rsp_t o;
    logic [63:0] lim;
    o = '0;
    case (r.req_type)
      rpt_pkg::REQ_ADD: begin
        if (pr_fill[c] >= ring_slots()) begin
          o.window_full_error = 1'b1;
        end else begin
          pr_ring[c][(pr_head[c] + pr_fill[c]) % ring_slots()] = r.index_a;
          pr_fill[c]++;
          o.accepted = 1'b1;
        end
      end
      rpt_pkg::REQ_FREE_TO: window_release(c, r.index_a);
      rpt_pkg::REQ_FREE_FIRST: begin
        if (pr_fill[c] != 0) window_release(c, pr_ring[c][pr_head[c]]);
      end
      rpt_pkg::REQ_ACK: begin
        if (pr_match[c] < r.index_a) begin
          pr_match[c] = r.index_a;
          pr_pause[c] = 1'b0;
          o.accepted = 1'b1;
        end
        if (pr_next[c] < step_up(r.index_a)) pr_next[c] = step_up(r.index_a);
      end
      rpt_pkg::REQ_REJECT: begin
        if (pr_mode[c] == rpt_pkg::MODE_REPLICATE) begin
          if (r.index_a > pr_match[c]) begin
            pr_next[c] = step_up(pr_match[c]);
            o.accepted = 1'b1;
          end
        end else if (pr_next[c] - 64'd1 == r.index_a) begin
          lim = step_up(r.index_b);
          pr_next[c] = (r.index_a < lim) ? r.index_a : lim;
          if (pr_next[c] == '0) pr_next[c] = 64'd1;
          pr_pause[c] = 1'b0;
          o.accepted = 1'b1;
        end
      end
      rpt_pkg::REQ_PROBE: begin
        // leaving snapshot resumes past whichever of match and pending is higher
        lim = (pr_mode[c] == rpt_pkg::MODE_SNAPSHOT && pr_pend[c] > pr_match[c]) ?
              pr_pend[c] : pr_match[c];
        switch_mode(c, rpt_pkg::MODE_PROBE);
        pr_next[c] = step_up(lim);
      end
      rpt_pkg::REQ_REPLICATE: begin
        switch_mode(c, rpt_pkg::MODE_REPLICATE);
        pr_next[c] = step_up(pr_match[c]);
      end
      rpt_pkg::REQ_SNAPSHOT: begin
        switch_mode(c, rpt_pkg::MODE_SNAPSHOT);
        pr_pend[c] = r.index_a;
      end
      rpt_pkg::REQ_PAUSE: pr_pause[c] = 1'b1;
      default: ;
    endcase

    o.mode = pr_mode[c];
    o.next_index = pr_next[c];
    o.match_index = pr_match[c];
    o.snapshot_index = pr_pend[c];
    case (pr_mode[c])
      rpt_pkg::MODE_PROBE:     o.is_paused_out = pr_pause[c];
      rpt_pkg::MODE_REPLICATE: o.is_paused_out = (pr_fill[c] >= ring_slots());
      default:                 o.is_paused_out = 1'b1;
    endcase
    o.snapshot_abort = (pr_mode[c] == rpt_pkg::MODE_SNAPSHOT) &&
                       (pr_match[c] >= pr_pend[c]);
    o.window_count = 9'(pr_fill[c]);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer(logic [3:0] kind, logic [63:0] a, logic [63:0] b);
    rpt_pkg::req_t r;
    r.req_type = kind;
    r.index_a = a;
    r.index_b = b;
    event_q.push_back(r);
    void'(follower_step(PLAN, r));
  endtask

  // One random event shaped by the planner's view of the follower
  task automatic random_event();
    int pick;
    logic [3:0] kind;
    logic [63:0] a;
    logic [63:0] b;
    pick = $urandom_range(0, 99);
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    if (pick < 24) begin
      kind = rpt_pkg::REQ_ADD;
      if ($urandom_range(0, 99) < 85) begin
        log_top = log_top + 64'($urandom_range(0, 2));
        a = log_top;
      end
    end else if (pick < 36) begin
      kind = rpt_pkg::REQ_FREE_TO;
      if (pr_fill[PLAN] > 0 && $urandom_range(0, 9) < 8)
        a = pr_ring[PLAN][(pr_head[PLAN] + $urandom_range(0, pr_fill[PLAN] - 1)) %
                          ring_slots()];
      else if ($urandom_range(0, 19) != 0)
        a = log_top - 64'($urandom_range(0, 20));
    end else if (pick < 42) begin
      kind = rpt_pkg::REQ_FREE_FIRST;
    end else if (pick < 56) begin
      kind = rpt_pkg::REQ_ACK;
      if ($urandom_range(0, 3) == 0) a = pr_match[PLAN] - 64'($urandom_range(0, 3));
      else a = pr_match[PLAN] + 64'($urandom_range(0, 6));
      if (a > log_top) log_top = a;
    end else if (pick < 70) begin
      kind = rpt_pkg::REQ_REJECT;
      if (pr_mode[PLAN] == rpt_pkg::MODE_REPLICATE) begin
        a = pr_match[PLAN] + 64'($urandom_range(0, 3)) - 64'd1;
      end else if ($urandom_range(0, 9) < 7) begin
        a = pr_next[PLAN] - 64'd1;
        if ($urandom_range(0, 1) == 0) b = a - 64'($urandom_range(0, 10));
      end else begin
        a = pr_next[PLAN] + 64'($urandom_range(0, 4));
      end
    end else if (pick < 75) begin
      kind = rpt_pkg::REQ_PROBE;
    end else if (pick < 81) begin
      kind = rpt_pkg::REQ_REPLICATE;
    end else if (pick < 85) begin
      kind = rpt_pkg::REQ_SNAPSHOT;
      a = pr_match[PLAN] + 64'($urandom_range(0, 30)) - 64'd10;
    end else if (pick < 91) begin
      kind = rpt_pkg::REQ_PAUSE;
    end else if (pick < 93) begin
      kind = 4'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
    end else begin
      // noise: any code, raw indexes; acks kept low so match stays usable
      kind = 4'($urandom_range(0, 15));
      if (kind == rpt_pkg::REQ_ACK) begin
        a = 64'($urandom_range(0, 2000));
        if (a > log_top) log_top = a;
      end
    end
    offer(kind, a, b);
  endtask

  // Sampled away from the clock edge so the driver's updates have settled
  task automatic drain();
    while (event_q.size() != 0 || req_valid || progress_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_window(logic [8:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_setting = v;
    for (int c = 0; c < 2; c++) begin
      pr_head[c] = 0;
      pr_fill[c] = 0;
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: presents queued transactions, random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        progress_due.push_back(follower_step(LIVE, req));
        sent++;
      end
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (event_q.size() != 0) begin
          req <= event_q.pop_front();
          req_valid <= 1'b1;
          send_gap = calm ? 0 : idle_len();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready: random stalls plus one long hold to back up the block
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (!hold_done && taken == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ready <= 1'b0;
      end else if (calm) begin
        rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (progress_due.size() == 0) begin
        $error("result arrived with no prediction pending");
        failures++;
      end else begin
        due = progress_due.pop_front();
        check_field("accepted", 64'(due.accepted), 64'(rsp.accepted));
        check_field("window_full_error", 64'(due.window_full_error),
                    64'(rsp.window_full_error));
        check_field("mode", 64'(due.mode), 64'(rsp.mode));
        check_field("next_index", due.next_index, rsp.next_index);
        check_field("match_index", due.match_index, rsp.match_index);
        check_field("snapshot_index", due.snapshot_index, rsp.snapshot_index);
        check_field("is_paused_out", 64'(due.is_paused_out), 64'(rsp.is_paused_out));
        check_field("snapshot_abort", 64'(due.snapshot_abort), 64'(rsp.snapshot_abort));
        check_field("window_count", 64'(due.window_count), 64'(rsp.window_count));
        checked++;
        if (due.window_full_error) full_seen++;
        if (due.snapshot_abort) abort_seen++;
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("** replication_progress_tracker: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [8:0] sizes [NUM_PHASES];
    sizes = '{9'd1, 9'd0, 9'd4, 9'd511, 9'd3, 9'd8, 9'd300, 9'd2, 9'd17, 9'd256};

    for (int c = 0; c < 2; c++) begin
      pr_mode[c] = rpt_pkg::MODE_PROBE;
      pr_next[c] = 64'd1;
      pr_match[c] = '0;
      pr_pend[c] = '0;
      pr_pause[c] = 1'b0;
      pr_head[c] = 0;
      pr_fill[c] = 0;
    end

    // Directed opening, full-size window from reset
    offer(rpt_pkg::REQ_ADD, 64'd10, '0);
    offer(rpt_pkg::REQ_ADD, 64'd10, '0);
    offer(rpt_pkg::REQ_ADD, 64'd12, '0);
    offer(rpt_pkg::REQ_ADD, rpt_pkg::ALL_ONES, '0);
    offer(rpt_pkg::REQ_FREE_FIRST, '0, '0);        // oldest plus its duplicate
    offer(rpt_pkg::REQ_FREE_TO, 64'd5, '0);        // bound under the oldest entry
    offer(rpt_pkg::REQ_FREE_TO, 64'd12, '0);
    offer(rpt_pkg::REQ_FREE_TO, rpt_pkg::ALL_ONES, '0);  // empties the window
    offer(rpt_pkg::REQ_FREE_FIRST, '0, '0);        // empty window
    offer(rpt_pkg::REQ_FREE_TO, '0, '0);
    offer(rpt_pkg::REQ_ACK, 64'd20, '0);
    offer(rpt_pkg::REQ_ACK, 64'd15, '0);           // stale
    offer(rpt_pkg::REQ_PAUSE, '0, '0);
    offer(rpt_pkg::REQ_REJECT, 64'd20, 64'd5);     // probe reject, hint lowers next
    offer(rpt_pkg::REQ_REJECT, 64'd3, '0);         // stale
    offer(rpt_pkg::REQ_REJECT, 64'd5, '0);         // next to 1
    offer(rpt_pkg::REQ_REJECT, '0, rpt_pkg::ALL_ONES);  // would reach 0, held at 1
    offer(rpt_pkg::REQ_SNAPSHOT, 64'd150, '0);
    offer(rpt_pkg::REQ_ACK, 64'd100, '0);          // snapshot still pending
    offer(rpt_pkg::REQ_PROBE, '0, '0);             // resume past pending snapshot
    offer(rpt_pkg::REQ_REPLICATE, rpt_pkg::ALL_ONES, rpt_pkg::ALL_ONES);
    offer(rpt_pkg::REQ_REJECT, 64'd90, '0);        // stale in replicate
    offer(rpt_pkg::REQ_REJECT, 64'd120, '0);
    offer(rpt_pkg::REQ_SNAPSHOT, 64'd50, '0);      // abort due at once
    offer(REQ_UNKNOWN_HI, rpt_pkg::ALL_ONES, rpt_pkg::ALL_ONES);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    drain();

    // Random phases, one window size each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      calm = (ph == 5);
      set_window(sizes[ph]);
      if (sizes[ph] > DEPTH) begin
        // fill the whole ring in replicate mode, then overflow twice
        offer(rpt_pkg::REQ_REPLICATE, '0, '0);
        repeat (DEPTH + 2) begin
          log_top = log_top + 64'd1;
          offer(rpt_pkg::REQ_ADD, log_top, '0);
        end
      end
      repeat (PHASE_ITEMS) random_event();
      drain();
    end
    calm = 1'b0;

    // Saturation at the top of the index range; match can never come back
    // down, so this goes last
    offer(rpt_pkg::REQ_ACK, rpt_pkg::ALL_ONES, '0);
    offer(rpt_pkg::REQ_PROBE, '0, '0);
    offer(rpt_pkg::REQ_REPLICATE, '0, '0);
    offer(rpt_pkg::REQ_REJECT, rpt_pkg::ALL_ONES, rpt_pkg::ALL_ONES);
    offer(rpt_pkg::REQ_ADD, rpt_pkg::ALL_ONES, '0);
    offer(rpt_pkg::REQ_SNAPSHOT, rpt_pkg::ALL_ONES, '0);
    offer(rpt_pkg::REQ_PROBE, '0, '0);
    drain();
    repeat (20) @(posedge clk);

    $display("Run covered %0d request transactions across %0d window sizes,",
             sent, NUM_PHASES + 1);
    $display("%0d results checked, %0d full-window rejects, %0d snapshot aborts.",
             checked, full_seen, abort_seen);
    if (failures == 0) begin
      $display("** replication_progress_tracker: PASSED **");
    end else begin
      $display("** replication_progress_tracker: FAILED **");
    end
    $finish;
  end

endmodule
